// ===== hdl/hcsl_pkg.sv =====
`default_nettype none

package hcsl_pkg;

    localparam int LINE_COUNT_BITS = 16;
    localparam int SIZE_BITS       = 64;
    localparam int DIGIT_BITS      = 5;
    localparam int EXT_BITS        = 8;
    localparam int CONSUMED_BITS   = 16;
    localparam int MAX_DIGITS      = 16;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // register indexes on the config port (paddr[2])
    localparam logic REG_MAX_HEX_DIGITS = 1'b0;
    localparam logic REG_ALLOW_OBS_TEXT = 1'b1;

    typedef enum logic [3:0] {
        PH_FIRST        = 4'd0,
        PH_HEX          = 4'd1,
        PH_SIZE_WS      = 4'd2,
        PH_NAME         = 4'd3,
        PH_NAME_POST    = 4'd4,
        PH_VAL_PRE      = 4'd5,
        PH_VAL_TOKEN    = 4'd6,
        PH_VAL_POST     = 4'd7,
        PH_QUOTED       = 4'd8,
        PH_ESCAPE       = 4'd9,
        PH_QUOTE_CLOSED = 4'd10,
        PH_LF           = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        ST_MORE = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] max_hex_digits;
        logic                  allow_obs_text;
    } t_cfg;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - 8'h30;
        end else if (b <= 8'h46) begin
            v = b - 8'h37;
        end else begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SP || b == CH_HT;
    endfunction

    function automatic logic is_tchar(input logic [7:0] b);
        logic r;
        r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
            (b >= 8'h61 && b <= 8'h7A);
        case (b) inside
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D,
            8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic is_qdtext(input logic [7:0] b, input logic obs);
        return b == CH_HT || b == CH_SP || b == 8'h21 ||
               (b >= 8'h23 && b <= 8'h5B) || (b >= 8'h5D && b <= 8'h7E) ||
               (b[7] && obs);
    endfunction

    function automatic logic is_escapable(input logic [7:0] b, input logic obs);
        return b == CH_HT || (b >= 8'h20 && b <= 8'h7E) || (b[7] && obs);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hcsl_cfg.sv =====
`default_nettype none

module hcsl_cfg (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output hcsl_pkg::t_cfg            o_cfg
);

    hcsl_pkg::t_cfg r_cfg;
    logic           wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_hex_digits <= hcsl_pkg::DIGIT_BITS'(hcsl_pkg::MAX_DIGITS);
            r_cfg.allow_obs_text <= 1'b0;
        end else if (wr) begin
            unique case (paddr[2])
                hcsl_pkg::REG_MAX_HEX_DIGITS:
                    r_cfg.max_hex_digits <= pwdata[hcsl_pkg::DIGIT_BITS-1:0];
                hcsl_pkg::REG_ALLOW_OBS_TEXT:
                    r_cfg.allow_obs_text <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hcsl_pkg::REG_MAX_HEX_DIGITS:
                prdata = 32'(r_cfg.max_hex_digits);
            hcsl_pkg::REG_ALLOW_OBS_TEXT:
                prdata = 32'(r_cfg.allow_obs_text);
            default: prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hdl/hcsl_core.sv =====
`default_nettype none

module hcsl_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire hcsl_pkg::t_cfg                       i_cfg,
    input  wire logic                                 i_in_valid,
    input  wire logic [7:0]                           i_in_byte,
    input  wire logic                                 i_out_ready,
    output logic                                      o_adv,
    output logic                                      o_out_valid,
    output logic [1:0]                                o_status,
    output logic [hcsl_pkg::SIZE_BITS-1:0]            o_chunk_size,
    output logic [hcsl_pkg::CONSUMED_BITS-1:0]        o_consumed,
    output logic [hcsl_pkg::EXT_BITS-1:0]             o_ext_count
);

    // line state
    hcsl_pkg::t_phase                       r_phase, n_phase;
    logic [hcsl_pkg::SIZE_BITS-1:0]         r_size, n_size;
    logic [hcsl_pkg::DIGIT_BITS-1:0]        r_digits, n_digits;
    logic [hcsl_pkg::LINE_COUNT_BITS-1:0]   r_len, n_len;
    logic [hcsl_pkg::EXT_BITS-1:0]          r_ext, n_ext;
    logic                                   r_named, n_named;

    // result register
    logic                                   r_out_valid;
    hcsl_pkg::t_status                      r_status;
    logic [hcsl_pkg::SIZE_BITS-1:0]         r_res_size;
    logic [hcsl_pkg::CONSUMED_BITS-1:0]     r_res_cons;
    logic [hcsl_pkg::EXT_BITS-1:0]          r_res_ext;

    hcsl_pkg::t_status                      st;
    logic [hcsl_pkg::DIGIT_BITS-1:0]        limit;
    logic [hcsl_pkg::LINE_COUNT_BITS-1:0]   len_inc;
    logic [hcsl_pkg::EXT_BITS-1:0]          ext_inc;
    logic [7:0]                             b;
    logic                                   obs;

    assign o_adv   = i_in_valid && (!r_out_valid || i_out_ready);
    assign b       = i_in_byte;
    assign obs     = i_cfg.allow_obs_text;
    assign len_inc = r_len + 1'b1;
    assign ext_inc = (&r_ext) ? r_ext : r_ext + 1'b1;

    always_comb begin
        if (i_cfg.max_hex_digits == '0) begin
            limit = hcsl_pkg::DIGIT_BITS'(1);
        end else if (i_cfg.max_hex_digits > hcsl_pkg::DIGIT_BITS'(hcsl_pkg::MAX_DIGITS)) begin
            limit = hcsl_pkg::DIGIT_BITS'(hcsl_pkg::MAX_DIGITS);
        end else begin
            limit = i_cfg.max_hex_digits;
        end
    end

    // per-byte grammar step
    always_comb begin
        st       = hcsl_pkg::ST_MORE;
        n_phase  = r_phase;
        n_size   = r_size;
        n_digits = r_digits;
        n_ext    = r_ext;
        n_named  = r_named;
        if (&r_len) begin
            st = hcsl_pkg::ST_BAD;   // line longer than the byte counter
        end else begin
            unique case (r_phase) inside
                hcsl_pkg::PH_FIRST: begin
                    if (hcsl_pkg::is_hex(b)) begin
                        n_size   = hcsl_pkg::SIZE_BITS'(hcsl_pkg::hex_val(b));
                        n_digits = hcsl_pkg::DIGIT_BITS'(1);
                        n_phase  = hcsl_pkg::PH_HEX;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_HEX: begin
                    if (hcsl_pkg::is_hex(b)) begin
                        if (r_digits >= limit) begin
                            st = hcsl_pkg::ST_BAD;
                        end else begin
                            n_size   = {r_size[hcsl_pkg::SIZE_BITS-5:0], hcsl_pkg::hex_val(b)};
                            n_digits = r_digits + 1'b1;
                        end
                    end else if (b == hcsl_pkg::CH_CR) begin
                        n_phase = hcsl_pkg::PH_LF;
                    end else if (hcsl_pkg::is_ws(b)) begin
                        n_phase = hcsl_pkg::PH_SIZE_WS;
                    end else if (b == hcsl_pkg::CH_SEMI) begin
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_SIZE_WS: begin
                    if (b == hcsl_pkg::CH_SEMI) begin
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else if (!hcsl_pkg::is_ws(b)) begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_NAME: begin
                    if (hcsl_pkg::is_tchar(b)) begin
                        n_named = 1'b1;
                    end else if (hcsl_pkg::is_ws(b)) begin
                        if (r_named) begin
                            n_phase = hcsl_pkg::PH_NAME_POST;
                        end
                    end else if (b == hcsl_pkg::CH_CR) begin
                        if (!r_named) begin
                            st = hcsl_pkg::ST_BAD;
                        end else begin
                            n_ext   = ext_inc;
                            n_phase = hcsl_pkg::PH_LF;
                        end
                    end else if (b == hcsl_pkg::CH_SEMI) begin
                        n_ext   = ext_inc;
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else if (b == hcsl_pkg::CH_EQ) begin
                        n_ext   = ext_inc;
                        n_phase = hcsl_pkg::PH_VAL_PRE;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_NAME_POST: begin
                    if (b == hcsl_pkg::CH_SEMI) begin
                        n_ext   = ext_inc;
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else if (b == hcsl_pkg::CH_EQ) begin
                        n_ext   = ext_inc;
                        n_phase = hcsl_pkg::PH_VAL_PRE;
                    end else if (!hcsl_pkg::is_ws(b)) begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_VAL_PRE: begin
                    if (hcsl_pkg::is_ws(b)) begin
                        n_phase = hcsl_pkg::PH_VAL_PRE;
                    end else if (b == hcsl_pkg::CH_DQUOTE) begin
                        n_phase = hcsl_pkg::PH_QUOTED;
                    end else if (hcsl_pkg::is_tchar(b)) begin
                        n_phase = hcsl_pkg::PH_VAL_TOKEN;
                    end else if (b == hcsl_pkg::CH_CR) begin
                        n_phase = hcsl_pkg::PH_LF;
                    end else if (b == hcsl_pkg::CH_SEMI) begin
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_VAL_TOKEN, hcsl_pkg::PH_QUOTE_CLOSED,
                hcsl_pkg::PH_VAL_POST: begin
                    // value token, closed quote and blanks share exits; blanks refuse CR
                    if (r_phase == hcsl_pkg::PH_VAL_TOKEN && hcsl_pkg::is_tchar(b)) begin
                        n_phase = hcsl_pkg::PH_VAL_TOKEN;
                    end else if (r_phase != hcsl_pkg::PH_VAL_POST &&
                                 b == hcsl_pkg::CH_CR) begin
                        n_phase = hcsl_pkg::PH_LF;
                    end else if (hcsl_pkg::is_ws(b)) begin
                        n_phase = hcsl_pkg::PH_VAL_POST;
                    end else if (b == hcsl_pkg::CH_SEMI) begin
                        n_phase = hcsl_pkg::PH_NAME;
                        n_named = 1'b0;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_QUOTED: begin
                    if (b == hcsl_pkg::CH_DQUOTE) begin
                        n_phase = hcsl_pkg::PH_QUOTE_CLOSED;
                    end else if (b == hcsl_pkg::CH_BSLASH) begin
                        n_phase = hcsl_pkg::PH_ESCAPE;
                    end else if (!hcsl_pkg::is_qdtext(b, obs)) begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_ESCAPE: begin
                    if (hcsl_pkg::is_escapable(b, obs)) begin
                        n_phase = hcsl_pkg::PH_QUOTED;
                    end else begin
                        st = hcsl_pkg::ST_BAD;
                    end
                end
                hcsl_pkg::PH_LF: begin
                    st = (b == hcsl_pkg::CH_LF) ? hcsl_pkg::ST_DONE : hcsl_pkg::ST_BAD;
                end
                default: st = hcsl_pkg::ST_BAD;
            endcase
        end
        n_len = len_inc;
        if (st != hcsl_pkg::ST_MORE) begin
            n_phase  = hcsl_pkg::PH_FIRST;
            n_size   = '0;
            n_digits = '0;
            n_len    = '0;
            n_ext    = '0;
            n_named  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hcsl_pkg::PH_FIRST;
            r_size   <= '0;
            r_digits <= '0;
            r_len    <= '0;
            r_ext    <= '0;
            r_named  <= 1'b0;
        end else if (o_adv) begin
            r_phase  <= n_phase;
            r_size   <= n_size;
            r_digits <= n_digits;
            r_len    <= n_len;
            r_ext    <= n_ext;
            r_named  <= n_named;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_status <= st;
            if (st == hcsl_pkg::ST_DONE) begin
                r_res_size <= r_size;
                r_res_cons <= hcsl_pkg::CONSUMED_BITS'(len_inc);
                r_res_ext  <= r_ext;
            end else begin
                r_res_size <= '0;
                r_res_cons <= '0;
                r_res_ext  <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_chunk_size = r_res_size;
    assign o_consumed   = r_res_cons;
    assign o_ext_count  = r_res_ext;

`ifndef ASSERT_OFF
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_adv && st != hcsl_pkg::ST_MORE |=> r_phase == hcsl_pkg::PH_FIRST && r_len == '0)
        else $error("line state not cleared after a final byte");
    a_digits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digits <= hcsl_pkg::DIGIT_BITS'(hcsl_pkg::MAX_DIGITS))
        else $error("digit count beyond the widest size");
    a_hex_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hcsl_pkg::PH_HEX |-> r_digits != '0)
        else $error("size phase without a digit");
    a_zero_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != hcsl_pkg::ST_DONE |->
            r_res_size == '0 && r_res_cons == '0 && r_res_ext == '0)
        else $error("result fields set on an incomplete line");
    a_done_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == hcsl_pkg::ST_DONE |-> r_res_cons >= 16'd3)
        else $error("complete line shorter than digit plus CRLF");
`endif

endmodule

`default_nettype wire

// ===== hdl/http_chunk_size_line_parser.sv =====
`default_nettype none

// HTTP chunk-size line parser.
// Input stream (s_axis): one raw byte of a "size [ext] CRLF" line per transaction.
// Output stream (m_axis): one result per input byte. tuser carries the status
// (need more, line complete, invalid); on a complete line tdata carries the
// hex size, the byte count including CRLF and the extension count, else zeros.
// After a complete or invalid result the next byte starts a new line.
// Config (APB): max_hex_digits at 0x0, allow_obs_text at 0x4, pready tied high;
// write only while the stream is idle.
// Throughput: one byte per cycle while m_axis_tready is high. Each byte's grammar
// step is a single state update between the input register and the result register.
// Pipeline: 2 register stages, the input register and then the result register.
// Stall: while m_axis_tready is low the result holds and one more byte can be
// parked in the input register; s_axis_tready then drops.
// Reset (i_rst_n, synchronous): empties both registers, restores the config
// reset values (16 digits, no obs-text) and starts a fresh line.
module http_chunk_size_line_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,   // [63:0] chunk_size, [79:64] consumed,
                                             // [87:80] ext_count
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    hcsl_pkg::t_cfg                             cfg;
    logic                                       r_in_valid;
    logic [7:0]                                 r_in_byte;
    logic                                       adv;
    logic [hcsl_pkg::SIZE_BITS-1:0]             chunk_size;
    logic [hcsl_pkg::CONSUMED_BITS-1:0]         consumed;
    logic [hcsl_pkg::EXT_BITS-1:0]              ext_count;

    hcsl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register: refills in the same cycle the core takes its byte
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    hcsl_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (r_in_valid),
        .i_in_byte    (r_in_byte),
        .i_out_ready  (m_axis_tready),
        .o_adv        (adv),
        .o_out_valid  (m_axis_tvalid),
        .o_status     (m_axis_tuser),
        .o_chunk_size (chunk_size),
        .o_consumed   (consumed),
        .o_ext_count  (ext_count)
    );

    assign m_axis_tdata = {ext_count, consumed, chunk_size};

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stage empty but not ready");
    a_adv_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> r_in_valid && (!m_axis_tvalid || m_axis_tready))
        else $error("byte consumed without room for its result");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> m_axis_tvalid)
        else $error("consumed byte produced no result");
`endif

endmodule

`default_nettype wire
